// ----- hw/rtl/b64_pkg.sv -----
// shared types, constants and the alphabet lookup for the base64 stream encoder
package b64_pkg;

	// ascii code of the padding character
	localparam logic [6:0] PAD_CHAR = 7'h3D;

	// group queue geometry
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// one complete or closed group of up to three bytes
	typedef struct packed {
		logic [23:0] triple;
		logic [1:0]  pads;
		logic        last;
	} b64_group_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} b64_qstat_t;

	// six-bit value to standard base64 alphabet character
	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] v7;
		v7 = {1'b0, v};
		priority if (v < 6'd26) begin
			return 7'h41 + v7;
		end else if (v < 6'd52) begin
			return 7'h47 + v7;
		end else if (v < 6'd62) begin
			return v7 - 7'd4;
		end else if (v == 6'd62) begin
			return 7'h2B;
		end else begin
			return 7'h2F;
		end
	endfunction

endpackage

// ----- hw/rtl/b64_ifs.sv -----
// stream channel interfaces: raw byte requests in, encoded character requests out
interface b64_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64_char_if;
	logic       valid;
	logic       ready;
	logic [6:0] ascii_char;
	logic       last_char;

	modport source(output valid, output ascii_char, output last_char, input ready);
	modport sink(input valid, input ascii_char, input last_char, output ready);
endinterface

// ----- hw/rtl/b64_front.sv -----
// front end: collects raw bytes into groups and closes partial groups on the last byte
module b64_front (
	input  logic                clk,
	input  logic                arst_n,
	b64_byte_if.sink            raw,
	input  b64_pkg::b64_qstat_t qstat,
	output logic                push,
	output b64_pkg::b64_group_t push_grp
);
	import b64_pkg::*;

	logic [15:0] pend_q;
	logic [1:0]  cnt_q;
	logic        accept;
	logic        close;

	// a byte is taken whenever the queue has room
	assign raw.ready = !qstat.full;
	assign accept    = raw.valid && raw.ready;
	assign close     = (cnt_q == 2'd2) || raw.last_byte;
	assign push      = accept && close;

	// build the group word and padding count
	always_comb begin
		push_grp.last = raw.last_byte;
		unique case (cnt_q)
			2'd0: begin
				push_grp.triple = {raw.data_byte, 16'h0000};
				push_grp.pads   = raw.last_byte ? 2'd2 : 2'd0;
			end
			2'd1: begin
				push_grp.triple = {pend_q[7:0], raw.data_byte, 8'h00};
				push_grp.pads   = raw.last_byte ? 2'd1 : 2'd0;
			end
			default: begin
				push_grp.triple = {pend_q, raw.data_byte};
				push_grp.pads   = 2'd0;
			end
		endcase
	end

	// held byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= close ? 2'd0 : cnt_q + 2'd1;
		end
	end

	// held bytes, earliest in the upper byte
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= {pend_q[7:0], raw.data_byte};
		end
	end

endmodule

// ----- hw/rtl/b64_queue.sv -----
// short group queue between the byte front end and the character back end
module b64_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  b64_pkg::b64_group_t push_grp,
	input  logic                pop,
	output b64_pkg::b64_group_t head,
	output b64_pkg::b64_qstat_t qstat
);
	import b64_pkg::*;

	b64_group_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign head        = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == (QPTR_W)'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == (QPTR_W)'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

endmodule

// ----- hw/rtl/b64_back.sv -----
// back end: turns each queued group into four characters, one per cycle while the output is not stalled
module b64_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64_pkg::b64_group_t head,
	input  b64_pkg::b64_qstat_t qstat,
	output logic                pop,
	b64_char_if.source          enc
);
	import b64_pkg::*;

	b64_group_t grp_q;
	logic       busy_q;
	logic [1:0] k_q;
	logic       ovalid_q;
	logic [6:0] ochar_q;
	logic       olast_q;

	logic       slot_free;
	logic       emit;
	logic       done;
	logic [5:0] sextet;
	logic       is_pad;
	logic [6:0] nxt_char;

	assign slot_free = !ovalid_q || enc.ready;
	assign emit      = busy_q && slot_free;
	assign done      = emit && (k_q == 2'd3);
	assign pop       = !qstat.empty && (!busy_q || done);

	// pick the current six bits, most significant first, or padding
	always_comb begin
		unique case (k_q)
			2'd0:    sextet = grp_q.triple[23:18];
			2'd1:    sextet = grp_q.triple[17:12];
			2'd2:    sextet = grp_q.triple[11:6];
			default: sextet = grp_q.triple[5:0];
		endcase
		is_pad   = ({1'b0, k_q} + {1'b0, grp_q.pads}) >= 3'd4;
		nxt_char = is_pad ? PAD_CHAR : b64_char(sextet);
	end

	// group slot and character index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			k_q      <= 2'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				k_q <= k_q + 2'd1;
			end
			if (emit) begin
				ovalid_q <= 1'b1;
			end else if (enc.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// group and output payload
	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
		if (emit) begin
			ochar_q <= nxt_char;
			olast_q <= grp_q.last && (k_q == 2'd3);
		end
	end

	assign enc.valid      = ovalid_q;
	assign enc.ascii_char = ochar_q;
	assign enc.last_char  = olast_q;

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// top level of the streaming base64 encoder
// Takes one raw byte per request on raw and returns standard base64 characters
// (alphabet A-Z a-z 0-9 + /, '=' padding) one per request on enc; the byte
// flagged last closes the group and its final character carries last_char.
// A byte is taken every cycle while the two-entry group queue has room; each
// group of three bytes becomes four characters, and the back end emits one
// character per cycle while the receiver is ready, so a long stream is paced by
// the single-character output register. A completed group is written into the
// group queue, then loaded into the back end's group slot, and its first
// character is then registered in the output register.
module base64_stream_encoder (
	input  logic        clk,
	input  logic        arst_n,
	b64_byte_if.sink    raw,
	b64_char_if.source  enc
);
	import b64_pkg::*;

	logic       push;
	logic       pop;
	b64_group_t push_grp;
	b64_group_t head;
	b64_qstat_t qstat;

	b64_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.raw      (raw),
		.qstat    (qstat),
		.push     (push),
		.push_grp (push_grp)
	);

	b64_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	b64_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.enc    (enc)
	);

	// no group is written into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) !(push && qstat.full))
		else $error("group pushed into full queue");

	// no group is taken from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) !(pop && qstat.empty))
		else $error("group popped from empty queue");

	// a push with no pop leaves the queue non-empty
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !qstat.empty)
		else $error("queue lost a pushed group");

	// a pop without a push leaves the queue not full
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> !qstat.full)
		else $error("queue still full after pop");

endmodule

// ----- tb/sv/base64_stream_encoder_tb.sv -----
// self-checking testbench for the streaming base64 encoder
module base64_stream_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import b64_pkg::*;

	// one raw byte request and one expected character
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} raw_req_t;

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} enc_char_t;

	logic clk;
	logic arst_n;

	b64_byte_if raw_ch();
	b64_char_if enc_ch();

	base64_stream_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.enc    (enc_ch)
	);

	string alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

	raw_req_t  raw_pend_q[$];
	enc_char_t enc_chars_q[$];

	// encoder state as predicted
	logic [15:0] held_bytes;
	logic [1:0]  held_cnt;

	int  src_idle_pct;
	int  snk_stall_pct;
	bit  hold_toggle;
	bit  raw_taken;
	int  errs;
	int  bytes_sent;
	int  chars_seen;
	int  msgs_queued;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic logic [6:0] base64_symbol(input logic [5:0] v);
		return 7'(alphabet[v]);
	endfunction

	// fold one accepted byte into the predicted state, queue any characters it closes
	task automatic encode_byte(input logic [7:0] b, input logic lst);
		logic [1:0]  n;
		logic [23:0] grp;
		int          npad;
		enc_char_t   c;
		n = (held_cnt > 2'd2) ? 2'd2 : held_cnt;
		if (n < 2'd2 && !lst) begin
			held_bytes = {held_bytes[7:0], b};
			held_cnt   = n + 2'd1;
			return;
		end
		case (n)
			2'd0: begin
				grp = {b, 16'h0000};
			end
			2'd1: begin
				grp = {held_bytes[7:0], b, 8'h00};
			end
			default: begin
				grp = {held_bytes, b};
			end
		endcase
		// none held closes with two pads, one held with one, two held with none
		npad = lst ? 2 - int'(n) : 0;
		for (int k = 0; k < 4; k++) begin
			c.ch   = (k >= 4 - npad) ? PAD_CHAR : base64_symbol(grp[23 - 6 * k -: 6]);
			c.last = lst && (k == 3);
			enc_chars_q.push_back(c);
		end
		held_bytes = '0;
		held_cnt   = '0;
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic lst);
		raw_req_t r;
		r.data = b;
		r.last = lst;
		raw_pend_q.push_back(r);
		bytes_sent++;
		if (lst) begin
			msgs_queued++;
		end
	endtask

	// random message, bytes biased toward the extremes now and then
	task automatic queue_message(input int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(7))
				0: b = 8'h00;
				1: b = 8'hFF;
				default: b = 8'($urandom);
			endcase
			queue_byte(b, i == len - 1);
		end
	endtask

	// random messages until at least min_bytes are queued
	task automatic queue_messages(input int min_bytes);
		int n;
		n = 0;
		while (n < min_bytes) begin
			int len;
			len = ($urandom_range(9) == 0) ? $urandom_range(20, 12) : $urandom_range(7, 1);
			queue_message(len);
			n += len;
		end
	endtask

	task automatic drain_requests();
		while (raw_pend_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// byte driver, changes on the falling edge, holds a request until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			raw_ch.valid <= 1'b0;
		end else if (raw_ch.valid && !raw_taken) begin
			raw_ch.valid <= 1'b1;
		end else if (raw_pend_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
			raw_ch.valid     <= 1'b1;
			raw_ch.data_byte <= raw_pend_q[0].data;
			raw_ch.last_byte <= raw_pend_q[0].last;
		end else begin
			raw_ch.valid     <= 1'b0;
			raw_ch.data_byte <= 8'($urandom);
			raw_ch.last_byte <= 1'($urandom);
		end
	end

	// byte acceptance feeds the predictor
	always @(posedge clk) begin
		raw_taken = arst_n && raw_ch.valid === 1'b1 && raw_ch.ready === 1'b1;
		if (raw_taken) begin
			encode_byte(raw_ch.data_byte, raw_ch.last_byte);
			void'(raw_pend_q.pop_front());
		end
	end

	// receiver ready, with a long hold-off on request
	bit hold_seen;
	int hold_left;
	always @(negedge clk) begin
		if (hold_toggle != hold_seen) begin
			hold_seen = hold_toggle;
			hold_left = 80;
		end
		if (hold_left > 0) begin
			hold_left--;
			enc_ch.ready <= 1'b0;
		end else begin
			enc_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// character monitor against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && enc_ch.valid === 1'b1 && enc_ch.ready === 1'b1) begin
			chars_seen++;
			if (enc_chars_q.size() == 0) begin
				errs++;
				if (errs <= 10) begin
					$display("unexpected character 0x%02h last=%0b", enc_ch.ascii_char,
						enc_ch.last_char);
				end
			end else begin
				enc_char_t e;
				e = enc_chars_q.pop_front();
				if (enc_ch.ascii_char !== e.ch || enc_ch.last_char !== e.last) begin
					errs++;
					if (errs <= 10) begin
						$display("mismatch at char %0d: expected 0x%02h last=%0b, got 0x%02h last=%0b",
							chars_seen, e.ch, e.last, enc_ch.ascii_char, enc_ch.last_char);
					end
				end
			end
		end
	end

	// stimulus and end of run
	initial begin
		raw_ch.valid     = 1'b0;
		raw_ch.data_byte = 8'h00;
		raw_ch.last_byte = 1'b0;
		enc_ch.ready     = 1'b0;
		held_bytes       = '0;
		held_cnt         = '0;
		src_idle_pct     = 0;
		snk_stall_pct    = 0;
		hold_toggle      = 1'b0;
		hold_seen        = 1'b0;
		hold_left        = 0;
		raw_taken        = 1'b0;
		errs             = 0;
		bytes_sent       = 0;
		chars_seen       = 0;
		msgs_queued      = 0;
		arst_n           = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single-byte messages at both extremes
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b1);
		// two-byte messages, one pad
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b1);
		// full group closed by the last byte
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h10, 1'b0);
		queue_byte(8'h83, 1'b1);
		// full groups without the last mark, then a single-byte tail
		queue_byte(8'hFB, 1'b0);
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'hBE, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b1);
		// full group then a two-byte tail, then another two-byte message
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h7F, 1'b1);
		queue_byte(8'h55, 1'b0);
		queue_byte(8'hAA, 1'b1);
		drain_requests();

		// random messages under each idling mix
		queue_messages(18);
		drain_requests();
		src_idle_pct = 54;
		queue_messages(18);
		drain_requests();
		src_idle_pct  = 0;
		snk_stall_pct = 54;
		queue_messages(18);
		drain_requests();
		src_idle_pct  = 10;
		snk_stall_pct = 10;
		queue_messages(18);
		drain_requests();

		// receiver holds off while bytes keep coming, so the group queue backs up
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_toggle   = ~hold_toggle;
		queue_message(15);
		drain_requests();

		while (enc_chars_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("sent %0d bytes in %0d messages, checked %0d characters", bytes_sent,
			msgs_queued, chars_seen);
		$display("idling mixes: none, sender, receiver, both, plus a long receiver hold-off");
		if (errs == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", errs);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
